@@ hdl/svf_pkg.sv @@
// Shared constants, operation codes and controller/datapath types for the state variable filter.
package svf_pkg;

   // Default widths
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int STATE_WIDTH_DEF  = 32;

   // Fixed field widths
   localparam int FS_W   = 18;
   localparam int CUT_W  = 16;
   localparam int DAMP_W = 16;
   localparam int OUT_W  = 24;
   localparam int Q30_W  = 32;

   // Sample rate and cutoff limits
   localparam logic [FS_W-1:0]  FS_MIN   = 18'd8000;
   localparam logic [FS_W-1:0]  FS_MAX   = 18'd192000;
   localparam logic [FS_W-1:0]  FS_RESET = 18'd48000;
   localparam logic [CUT_W-1:0] FC_MIN   = 16'd20;

   // Q2.30 constants
   localparam logic [Q30_W-1:0] PI_Q30    = 32'd3373259426;
   localparam logic [Q30_W-1:0] ONE_Q30   = 32'd1073741824;
   localparam logic [Q30_W-1:0] F_MAX_Q30 = 32'd1020054733;
   localparam logic [Q30_W:0]   FOUR_Q30  = 33'h1_0000_0000;

   // Damping bound: 0.98/2 * 4096 = 49*4096/100
   localparam logic [DAMP_W-1:0] Q_MIN_Q12  = 16'd410;
   localparam logic [Q30_W-1:0]  QMAX_SCALE = 32'd200704;
   localparam logic [Q30_W-1:0]  DEN_SCALE  = 32'd100;

   // Serial divider sizes
   localparam int DIV_W     = 52;
   localparam int DVS_W     = 40;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // Taylor series divisors as reciprocals: floor(v/d) = (v*R) >> SH, exact for 32-bit v
   localparam logic [Q30_W:0] RCP_42    = 33'd6544712071;
   localparam int             RCP_42_SH = 38;
   localparam logic [Q30_W:0] RCP_20    = 33'd3435973837;
   localparam int             RCP_20_SH = 36;
   localparam logic [Q30_W:0] RCP_6     = 33'd2863311531;
   localparam int             RCP_6_SH  = 34;

   // Datapath operations, one per controller step
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_IDLE = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD = 5'd1;
   localparam logic [OP_W-1:0] OP_DIVX = 5'd2;
   localparam logic [OP_W-1:0] OP_WX   = 5'd3;
   localparam logic [OP_W-1:0] OP_MT   = 5'd4;
   localparam logic [OP_W-1:0] OP_MT2  = 5'd5;
   localparam logic [OP_W-1:0] OP_D42  = 5'd6;
   localparam logic [OP_W-1:0] OP_WA   = 5'd7;
   localparam logic [OP_W-1:0] OP_MA   = 5'd8;
   localparam logic [OP_W-1:0] OP_D20  = 5'd9;
   localparam logic [OP_W-1:0] OP_WB   = 5'd10;
   localparam logic [OP_W-1:0] OP_MB   = 5'd11;
   localparam logic [OP_W-1:0] OP_D6   = 5'd12;
   localparam logic [OP_W-1:0] OP_WC   = 5'd13;
   localparam logic [OP_W-1:0] OP_MS   = 5'd14;
   localparam logic [OP_W-1:0] OP_FSET = 5'd15;
   localparam logic [OP_W-1:0] OP_MF2  = 5'd16;
   localparam logic [OP_W-1:0] OP_MNUM = 5'd17;
   localparam logic [OP_W-1:0] OP_MDEN = 5'd18;
   localparam logic [OP_W-1:0] OP_DQ   = 5'd19;
   localparam logic [OP_W-1:0] OP_WQ   = 5'd20;
   localparam logic [OP_W-1:0] OP_MLOW = 5'd21;
   localparam logic [OP_W-1:0] OP_MQB  = 5'd22;
   localparam logic [OP_W-1:0] OP_MFH  = 5'd23;
   localparam logic [OP_W-1:0] OP_HOLD = 5'd24;
   localparam logic [OP_W-1:0] OP_UPD  = 5'd25;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic big;
      logic div_done;
   } stat_type;

endpackage

@@ hdl/svf_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module svf_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [svf_pkg::DIV_W-1:0]   dividend,
   input  logic [svf_pkg::DVS_W-1:0]   divisor,
   output logic                        done,
   output logic [svf_pkg::DIV_W-1:0]   quotient
);
   import svf_pkg::*;

   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [DVS_W-1:0]     dvs_ff;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DVS_W:0]       rem_sh;
   logic                 ge;

   // One restoring step
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DIV_W-1]};
      ge     = rem_sh >= {1'b0, dvs_ff};
      rem_in = ge ? DVS_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DVS_W-1:0];
      dvd_in = {dvd_ff[DIV_W-2:0], ge};
   end

   // Iteration control
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand and partial remainder registers
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

@@ hdl/svf_dp.sv @@
// Datapath: coefficient math, shared multiplier, filter state and result register.
module svf_dp #(
   parameter int SAMPLE_WIDTH = svf_pkg::SAMPLE_WIDTH_DEF,
   parameter int STATE_WIDTH  = svf_pkg::STATE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  svf_pkg::cmd_type                  cmd,
   output svf_pkg::stat_type                 stat,
   input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
   input  logic [svf_pkg::CUT_W-1:0]         cutoff_hz,
   input  logic [svf_pkg::DAMP_W-1:0]        damping,
   input  logic                              csr_write,
   input  logic [svf_pkg::FS_W-1:0]          csr_data,
   output logic signed [svf_pkg::OUT_W-1:0]  lowpass_out,
   output logic                              state_cleared
);
   import svf_pkg::*;

   localparam int EW   = STATE_WIDTH + 6;
   localparam int MW   = (STATE_WIDTH + 7 > 34) ? STATE_WIDTH + 7 : 34;
   localparam int PW   = 2 * MW;
   localparam int SH_L = (SAMPLE_WIDTH <= 25) ? 25 - SAMPLE_WIDTH : 0;
   localparam int SH_R = (SAMPLE_WIDTH > 25) ? SAMPLE_WIDTH - 25 : 0;
   localparam int SXW  = SAMPLE_WIDTH + SH_L;

   // Registers
   logic [FS_W-1:0]                fs_cfg_ff;
   logic [FS_W-1:0]                fs_ff;
   logic [CUT_W-1:0]               cut_ff;
   logic [DAMP_W-1:0]              qin_ff;
   logic [DAMP_W-1:0]              q_ff;
   logic signed [SAMPLE_WIDTH-1:0] smp_ff;
   logic                           big_ff;
   logic [Q30_W-1:0]               x_ff, t_ff, t2_ff, a_ff, b_ff, c_ff, f_ff;
   logic [DIV_W-1:0]               divnum_ff;
   logic signed [PW-1:0]           prod_ff, prod_in;
   logic signed [EW-1:0]           low_ff;
   logic signed [STATE_WIDTH-1:0]  low_state_ff, band_state_ff;
   logic signed [STATE_WIDTH-1:0]  low_state_in, band_state_in;
   logic signed [OUT_W-1:0]        out_ff, out_in;
   logic                           clr_ff;

   // Combinational
   logic [FS_W-1:0]                fs_clamp;
   logic [CUT_W-1:0]               cut_clamp;
   logic [Q30_W-1:0]               prod_q30, prod_q32;
   logic [Q30_W:0]                 s_x2;
   logic [Q30_W-1:0]               f_calc;
   logic [Q30_W:0]                 num;
   logic signed [MW-1:0]           mul_a, mul_b;
   logic signed [SXW-1:0]          sx, sxr;
   logic signed [EW-1:0]           x_ext, high, low_new, band_new;
   logic signed [EW-1:0]           prod_s30, prod_s12, lo_sh;
   logic                           ovf;
   logic                           div_start;
   logic [DIV_W-1:0]               div_dvd;
   logic [DVS_W-1:0]               div_dvs;
   logic                           div_done;
   logic [DIV_W-1:0]               div_quo;
   logic [DAMP_W-1:0]              q_clamp;

   function automatic logic signed [MW-1:0] ux(input logic [Q30_W:0] v);
      ux = $signed(MW'(v));
   endfunction

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_cfg_ff <= FS_RESET;
      end else if (csr_write) begin
         fs_cfg_ff <= csr_data;
      end
   end

   // Clamps on the incoming transaction
   always_comb begin
      fs_clamp  = (fs_cfg_ff < FS_MIN) ? FS_MIN : ((fs_cfg_ff > FS_MAX) ? FS_MAX : fs_cfg_ff);
      cut_clamp = (cutoff_hz < FC_MIN) ? FC_MIN : cutoff_hz;
   end

   // Product slices
   assign prod_q30 = prod_ff[61:30];
   assign prod_q32 = prod_ff[63:32];
   assign prod_s30 = EW'(prod_ff >>> 30);
   assign prod_s12 = EW'(prod_ff >>> 12);

   // f = 2*s, capped, never zero
   always_comb begin
      s_x2 = {prod_q30, 1'b0};
      if (big_ff || s_x2 > {1'b0, F_MAX_Q30}) begin
         f_calc = F_MAX_Q30;
      end else if (s_x2 == '0) begin
         f_calc = 32'd1;
      end else begin
         f_calc = s_x2[Q30_W-1:0];
      end
      num = FOUR_Q30 - {1'b0, prod_q30};
   end

   // Sample to Q8.24
   assign sx    = SXW'(smp_ff) <<< SH_L;
   assign sxr   = sx >>> SH_R;
   assign x_ext = EW'(sxr);

   // Filter update terms
   assign low_new  = EW'(low_state_ff) + prod_s30;
   assign high     = x_ext - low_ff - prod_s12;
   assign band_new = prod_s30 + EW'(band_state_ff);

   // Damping clamp against the divider result
   always_comb begin
      if (qin_ff < Q_MIN_Q12) begin
         q_clamp = Q_MIN_Q12;
      end else if (DIV_W'(qin_ff) > div_quo) begin
         q_clamp = div_quo[DAMP_W-1:0];
      end else begin
         q_clamp = qin_ff;
      end
   end

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MT: begin
            mul_a = ux({1'b0, x_ff});
            mul_b = ux({1'b0, PI_Q30});
         end
         OP_MT2: begin
            mul_a = ux({1'b0, prod_q32});
            mul_b = ux({1'b0, prod_q32});
         end
         OP_D42: begin
            mul_a = ux({1'b0, prod_q30});
            mul_b = ux(RCP_42);
         end
         OP_MA: begin
            mul_a = ux({1'b0, t2_ff});
            mul_b = ux({1'b0, a_ff});
         end
         OP_D20: begin
            mul_a = ux({1'b0, prod_q30});
            mul_b = ux(RCP_20);
         end
         OP_MB: begin
            mul_a = ux({1'b0, t2_ff});
            mul_b = ux({1'b0, b_ff});
         end
         OP_D6: begin
            mul_a = ux({1'b0, prod_q30});
            mul_b = ux(RCP_6);
         end
         OP_MS: begin
            mul_a = ux({1'b0, t_ff});
            mul_b = ux({1'b0, c_ff});
         end
         OP_MF2: begin
            mul_a = ux({1'b0, f_ff});
            mul_b = ux({1'b0, f_ff});
         end
         OP_MNUM: begin
            mul_a = ux(num);
            mul_b = ux({1'b0, QMAX_SCALE});
         end
         OP_MDEN: begin
            mul_a = ux({1'b0, f_ff});
            mul_b = ux({1'b0, DEN_SCALE});
         end
         OP_MLOW: begin
            mul_a = ux({1'b0, f_ff});
            mul_b = MW'(band_state_ff);
         end
         OP_MQB: begin
            mul_a = ux(33'(q_ff));
            mul_b = MW'(band_state_ff);
         end
         OP_MFH: begin
            mul_a = ux({1'b0, f_ff});
            mul_b = MW'(high);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // Divider operand select
   always_comb begin
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = '0;
      case (cmd.op)
         OP_DIVX: begin
            div_start = !big_ff;
            div_dvd   = DIV_W'({cut_ff, 32'd0});
            div_dvs   = DVS_W'(fs_ff);
         end
         OP_DQ: begin
            div_start = 1'b1;
            div_dvd   = divnum_ff;
            div_dvs   = prod_ff[DVS_W-1:0];
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   svf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   // State update with overflow clear
   always_comb begin
      ovf = !((&low_ff[EW-1:STATE_WIDTH-1]) || !(|low_ff[EW-1:STATE_WIDTH-1]))
         || !((&band_new[EW-1:STATE_WIDTH-1]) || !(|band_new[EW-1:STATE_WIDTH-1]));
      low_state_in  = ovf ? '0 : STATE_WIDTH'(low_ff);
      band_state_in = ovf ? '0 : STATE_WIDTH'(band_new);
      lo_sh = EW'(low_state_in) >>> 4;
      if ((&lo_sh[EW-1:OUT_W-1]) || !(|lo_sh[EW-1:OUT_W-1])) begin
         out_in = lo_sh[OUT_W-1:0];
      end else if (lo_sh[EW-1]) begin
         out_in = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         out_in = {1'b0, {(OUT_W-1){1'b1}}};
      end
   end

   // Filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         low_state_ff  <= '0;
         band_state_ff <= '0;
      end else if (cmd.op == OP_UPD) begin
         low_state_ff  <= low_state_in;
         band_state_ff <= band_state_in;
      end
   end

   // Working registers; the f*high product is held while the update waits
   always_ff @(posedge clock) begin
      if (cmd.op != OP_HOLD) begin
         prod_ff <= prod_in;
      end
      case (cmd.op)
         OP_LOAD: begin
            smp_ff <= in_sample;
            cut_ff <= cut_clamp;
            qin_ff <= damping;
            fs_ff  <= fs_clamp;
            big_ff <= ({2'b00, cut_clamp} + {1'b0, cut_clamp, 1'b0}) > fs_clamp;
         end
         OP_WX:   if (div_done) x_ff <= div_quo[Q30_W-1:0];
         OP_MT2:  t_ff <= prod_q32;
         OP_D42:  t2_ff <= prod_q30;
         OP_WA:   a_ff <= ONE_Q30 - prod_ff[RCP_42_SH+Q30_W-1:RCP_42_SH];
         OP_WB:   b_ff <= ONE_Q30 - prod_ff[RCP_20_SH+Q30_W-1:RCP_20_SH];
         OP_WC:   c_ff <= ONE_Q30 - prod_ff[RCP_6_SH+Q30_W-1:RCP_6_SH];
         OP_FSET: f_ff <= f_calc;
         OP_MDEN: divnum_ff <= prod_ff[DIV_W-1:0];
         OP_WQ:   if (div_done) q_ff <= q_clamp;
         OP_MQB:  low_ff <= low_new;
         OP_UPD: begin
            out_ff <= out_in;
            clr_ff <= ovf;
         end
         default: begin
         end
      endcase
   end

   assign stat.big      = big_ff;
   assign stat.div_done = div_done;
   assign lowpass_out   = out_ff;
   assign state_cleared = clr_ff;

endmodule

@@ hdl/svf_ctrl.sv @@
// Controller: sequences the datapath operations and runs both handshakes.
module svf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output svf_pkg::cmd_type   cmd,
   input  svf_pkg::stat_type  stat
);
   import svf_pkg::*;

   logic [OP_W-1:0] st_ff, st_in;
   logic            vld_ff, vld_in;

   // Step sequence
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         OP_IDLE: if (req_valid) st_in = OP_LOAD;
         OP_LOAD: st_in = OP_DIVX;
         OP_DIVX: st_in = stat.big ? OP_FSET : OP_WX;
         OP_WX:   if (stat.div_done) st_in = OP_MT;
         OP_MT:   st_in = OP_MT2;
         OP_MT2:  st_in = OP_D42;
         OP_D42:  st_in = OP_WA;
         OP_WA:   st_in = OP_MA;
         OP_MA:   st_in = OP_D20;
         OP_D20:  st_in = OP_WB;
         OP_WB:   st_in = OP_MB;
         OP_MB:   st_in = OP_D6;
         OP_D6:   st_in = OP_WC;
         OP_WC:   st_in = OP_MS;
         OP_MS:   st_in = OP_FSET;
         OP_FSET: st_in = OP_MF2;
         OP_MF2:  st_in = OP_MNUM;
         OP_MNUM: st_in = OP_MDEN;
         OP_MDEN: st_in = OP_DQ;
         OP_DQ:   st_in = OP_WQ;
         OP_WQ:   if (stat.div_done) st_in = OP_MLOW;
         OP_MLOW: st_in = OP_MQB;
         OP_MQB:  st_in = OP_MFH;
         OP_MFH:  st_in = OP_HOLD;
         OP_HOLD: if (!vld_ff || !rsp_stall) st_in = OP_UPD;
         OP_UPD:  st_in = OP_IDLE;
         default: st_in = OP_IDLE;
      endcase
   end

   // Result valid: set on update, cleared when the transaction is taken
   always_comb begin
      vld_in = vld_ff;
      if (st_ff == OP_UPD) begin
         vld_in = 1'b1;
      end else if (vld_ff && !rsp_stall) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= OP_IDLE;
         vld_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         vld_ff <= vld_in;
      end
   end

   // The input transaction is taken in the load step, where the datapath captures it
   assign cmd.op    = st_ff;
   assign req_stall = (st_ff != OP_LOAD);
   assign rsp_valid = vld_ff;

endmodule

@@ hdl/state_variable_lowpass_filter.sv @@
// Top level of the fixed-point state variable low-pass filter.
// One audio sample per transaction: the cutoff is clamped to at least 20 Hz, the
// coefficient f = 2*sin(pi*fc/fs) is formed by a Taylor series (capped at 0.95,
// and set to 0.95 when the cutoff is above fs/3), damping is clamped to [0.1,
// 0.98*(4-f^2)/(2f)], and one Chamberlin update runs on Q8.24 state. State overflow
// clears both states and sets rsp_state_cleared. Samples are processed one at a time.
// The work is done by the bit-serial divider (two divisions per sample, one when the
// cutoff is above fs/3) and the single shared multiplier; the Taylor series
// divisions by constants are reciprocal multiplications. The sample is taken the
// cycle after req_valid is seen. A finished result sits in an output register, so
// the next sample is taken while it waits; if it still waits when the next update
// is due, that update holds until it is taken. csr_ready is always high; write the
// sample rate only while idle.
module state_variable_lowpass_filter #(
   parameter int SAMPLE_WIDTH = svf_pkg::SAMPLE_WIDTH_DEF,
   parameter int STATE_WIDTH  = svf_pkg::STATE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_in_sample,
   input  logic [svf_pkg::CUT_W-1:0]         req_cutoff_hz,
   input  logic [svf_pkg::DAMP_W-1:0]        req_damping,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [svf_pkg::OUT_W-1:0]  rsp_lowpass_out,
   output logic                              rsp_state_cleared,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [svf_pkg::FS_W-1:0]          csr_sample_rate_hz
);
   import svf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   svf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   svf_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .STATE_WIDTH  (STATE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .in_sample     (req_in_sample),
      .cutoff_hz     (req_cutoff_hz),
      .damping       (req_damping),
      .csr_write     (csr_valid && csr_ready),
      .csr_data      (csr_sample_rate_hz),
      .lowpass_out   (rsp_lowpass_out),
      .state_cleared (rsp_state_cleared)
   );

endmodule
